[hw/rtl/isb_pkg.sv]
package isb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int CNT_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int IDX_W   = $clog2(LINE_DEPTH);
  localparam int SIZE_W  = 11;
  localparam int COORD_W = 11;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = PIX_W + 1;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int PHASE_W = 2;

  localparam logic [ADDR_W-3:0] REG_SCALE_MODE   = 2'd0;
  localparam logic [ADDR_W-3:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [ADDR_W-3:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic MODE_ZOOM_IN  = 1'b0;
  localparam logic MODE_ZOOM_OUT = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

  localparam logic [SIZE_W-1:0] WIDTH_BOUND  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_BOUND = SIZE_W'(MAX_HEIGHT);

  typedef struct packed {
    logic              scale_mode;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              restart;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               multi;
  } item_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] bound);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > bound) begin
      r = bound;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/isb_regs.sv]
module isb_regs import isb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic              scale_mode;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              wr;
  logic [ADDR_W-3:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode   <= MODE_ZOOM_IN;
      frame_width  <= WIDTH_BOUND;
      frame_height <= HEIGHT_BOUND;
    end else if (wr) begin
      case (idx)
        REG_SCALE_MODE:   scale_mode   <= pwdata[0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCALE_MODE:   prdata = DATA_W'(scale_mode);
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // any write to a known register restarts the frame
  assign cfg.scale_mode = scale_mode;
  assign cfg.width      = clamp_size(frame_width, WIDTH_BOUND);
  assign cfg.height     = clamp_size(frame_height, HEIGHT_BOUND);
  assign cfg.restart    = wr && (idx == REG_SCALE_MODE || idx == REG_FRAME_WIDTH ||
                                 idx == REG_FRAME_HEIGHT);

endmodule

[hw/rtl/isb_front.sv]
module isb_front import isb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             item_valid,
  input  logic             item_ready,
  output item_t            item
);

  logic [CNT_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [PIX_W-1:0]  left_pixel;
  logic              col_wrap;
  logic              row_wrap;
  logic              accept;
  logic              buf_wr;
  logic [IDX_W-1:0]  buf_idx;
  logic [SUM_W-1:0]  pair_in;
  logic [SUM_W-1:0]  line_mem [LINE_DEPTH];

  // stage a
  logic              a_valid;
  logic              a_emit;
  logic              a_mode;
  logic [PIX_W-1:0]  a_pix;
  logic [PIX_W-1:0]  a_left;
  logic [CNT_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [SUM_W-1:0]  a_sum;
  logic              a_adv;
  logic [SUM_W-1:0]  a_pair;
  logic [SUM_W:0]    a_total;

  assign a_adv    = a_valid && (!a_emit || item_ready);
  assign in_ready = !a_valid || a_adv;
  assign accept   = in_valid && in_ready;

  assign col_wrap = (SIZE_W'(col_cnt) + SIZE_W'(1)) >= cfg.width;
  assign row_wrap = (SIZE_W'(row_cnt) + SIZE_W'(1)) >= cfg.height;

  assign buf_idx = col_cnt[CNT_W-1:1];
  assign pair_in = SUM_W'(left_pixel) + SUM_W'(pixel_in);
  assign buf_wr  = accept && cfg.scale_mode == MODE_ZOOM_OUT && col_cnt[0] && !row_cnt[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      left_pixel <= '0;
      a_valid    <= 1'b0;
    end else begin
      if (cfg.restart) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (accept) begin
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_wrap ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= col_cnt + CNT_W'(1);
        end
      end
      if (accept && cfg.scale_mode == MODE_ZOOM_OUT && !col_cnt[0]) begin
        left_pixel <= pixel_in;
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode <= cfg.scale_mode;
      a_pix  <= pixel_in;
      a_left <= left_pixel;
      a_col  <= col_cnt;
      a_row  <= row_cnt;
      a_emit <= cfg.scale_mode == MODE_ZOOM_IN || (col_cnt[0] && row_cnt[0]);
    end
  end

  // line buffer of even-row pair sums
  always_ff @(posedge clk) begin
    if (buf_wr) begin
      line_mem[buf_idx] <= pair_in;
    end
    if (accept) begin
      a_sum <= line_mem[buf_idx];
    end
  end

  assign a_pair  = SUM_W'(a_left) + SUM_W'(a_pix);
  assign a_total = (SUM_W + 1)'(a_sum) + (SUM_W + 1)'(a_pair);

  always_comb begin
    item_valid = a_valid && a_emit;
    if (a_mode == MODE_ZOOM_IN) begin
      item.pix   = a_pix;
      item.row   = COORD_W'({a_row, 1'b0});
      item.col   = COORD_W'({a_col, 1'b0});
      item.multi = 1'b1;
    end else begin
      item.pix   = a_total[SUM_W:2];
      item.row   = COORD_W'(a_row >> 1);
      item.col   = COORD_W'(a_col >> 1);
      item.multi = 1'b0;
    end
  end

  a_cnt_in_frame: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(col_cnt) < cfg.width && SIZE_W'(row_cnt) < cfg.height)
    else $error("pixel counters outside frame");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> a_valid && $stable(a_pix) && $stable(a_col))
    else $error("stalled stage a transaction lost");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_emit && !item_ready |-> !in_ready)
    else $error("input taken while stage a blocked");

endmodule

[hw/rtl/isb_out.sv]
module isb_out import isb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   pixel_out,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               last_of_run
);

  logic               o_valid;
  item_t              o_item;
  logic [PHASE_W-1:0] phase;
  logic               load;

  assign last_of_run = !o_item.multi || phase == PHASE_LAST;
  assign item_ready  = !o_valid || (out_ready && last_of_run);
  assign load        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      phase   <= '0;
    end else if (load) begin
      o_valid <= 1'b1;
      phase   <= '0;
    end else if (o_valid && out_ready) begin
      if (last_of_run) begin
        o_valid <= 1'b0;
        phase   <= '0;
      end else begin
        phase <= phase + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_item <= item;
    end
  end

  // block pixels walk in raster order inside the 2x2 block
  assign out_valid = o_valid;
  assign pixel_out = o_item.pix;
  assign out_row   = {o_item.row[COORD_W-1:1], o_item.row[0] | phase[1]};
  assign out_col   = {o_item.col[COORD_W-1:1], o_item.col[0] | phase[0]};

  a_single_phase: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_item.multi |-> phase == '0)
    else $error("zoom-out result beyond first phase");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> phase == '0)
    else $error("phase left over while empty");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    o_valid && out_ready && !last_of_run |=> o_valid && phase == $past(phase) + PHASE_W'(1))
    else $error("zoom-in run cut short");

endmodule

[hw/rtl/image_scale_by_two.sv]
// channel   handshake              payload
// config    psel/penable/pready    paddr, pwdata, prdata (scale_mode, frame_width, frame_height)
// input     in_valid/in_ready      pixel_in
// output    out_valid/out_ready    pixel_out, out_row, out_col, last_of_run
//
// zoom-in: four output transactions per pixel, one per cycle unless out_ready stalls,
//   serialized by the single output register walking the 2x2 block
// zoom-out: one pixel per cycle unless stalled; one result per odd-row odd-column pixel
// reset (rst, synchronous) clears counters, pipeline valids and registers to their defaults
// the line buffer needs no clearing; a write to a known register restarts the frame at row 0, column 0
// output stalls back up through the stage register into in_ready
module image_scale_by_two import isb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   pixel_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   pixel_out,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               last_of_run
);

  cfg_t  cfg;
  logic  item_valid;
  logic  item_ready;
  item_t item;

  isb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  isb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  isb_out u_out (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_out   (pixel_out),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_of_run (last_of_run)
  );

endmodule

[verif/scaled_pixel_checker.sv]
module scaled_pixel_checker import isb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [PIX_W-1:0]   pixel_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PIX_W-1:0]   pixel_out,
  input  logic [COORD_W-1:0] out_row,
  input  logic [COORD_W-1:0] out_col,
  input  logic               last_of_run,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int REPORT_CAP = 100;

  logic              scale_mode;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [SIZE_W-1:0] next_col;
  logic [SIZE_W-1:0] next_row;
  logic [PIX_W-1:0]  left_pix;
  logic [SUM_W-1:0]  row_pair_sums [LINE_DEPTH];
  item_t             pending_pixels [$];
  item_t             seen;
  item_t             want;
  int                errors = 0;

  function automatic item_t scaled_pixel(input logic [PIX_W-1:0] pix,
                                         input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] col,
                                         input logic last);
    item_t it;
    it.pix = pix;
    it.row = row;
    it.col = col;
    it.multi = last;
    return it;
  endfunction

  task automatic scale_pixel(input logic [PIX_W-1:0] pix);
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [SIZE_W-1:0] r;
    logic [SIZE_W-1:0] c;
    logic [SUM_W-1:0]  pair;
    logic [SUM_W:0]    block_sum;
    logic [IDX_W-1:0]  idx;
    w = (width_reg == '0) ? SIZE_W'(1) :
        (width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_reg;
    h = (height_reg == '0) ? SIZE_W'(1) :
        (height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_reg;
    if (next_col >= w) next_col = '0;
    if (next_row >= h) next_row = '0;
    r = next_row;
    c = next_col;
    if (scale_mode == MODE_ZOOM_IN) begin
      // 2x2 block in raster order
      pending_pixels.push_back(scaled_pixel(pix, {r[9:0], 1'b0}, {c[9:0], 1'b0}, 1'b0));
      pending_pixels.push_back(scaled_pixel(pix, {r[9:0], 1'b0}, {c[9:0], 1'b1}, 1'b0));
      pending_pixels.push_back(scaled_pixel(pix, {r[9:0], 1'b1}, {c[9:0], 1'b0}, 1'b0));
      pending_pixels.push_back(scaled_pixel(pix, {r[9:0], 1'b1}, {c[9:0], 1'b1}, 1'b1));
    end else if (!c[0]) begin
      left_pix = pix;
    end else begin
      pair = left_pix + pix;
      idx = c[IDX_W:1];
      if (!r[0]) begin
        row_pair_sums[idx] = pair;
      end else begin
        block_sum = row_pair_sums[idx] + pair;
        pending_pixels.push_back(scaled_pixel(block_sum[SUM_W:2], r >> 1, c >> 1, 1'b1));
      end
    end
    next_col = c + 1'b1;
    if (next_col >= w) begin
      next_col = '0;
      next_row = r + 1'b1;
      if (next_row >= h) next_row = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scale_mode = MODE_ZOOM_IN;
      width_reg = WIDTH_BOUND;
      height_reg = HEIGHT_BOUND;
      next_col = '0;
      next_row = '0;
      left_pix = '0;
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = scaled_pixel(pixel_out, out_row, out_col, last_of_run);
        if (pending_pixels.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected transaction pixel %0d row %0d col %0d last %0b",
                     $time, seen.pix, seen.row, seen.col, seen.multi);
        end else begin
          want = pending_pixels.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: expected pixel %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                       $time, want.pix, want.row, want.col, want.multi,
                       seen.pix, seen.row, seen.col, seen.multi);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SCALE_MODE: begin
            scale_mode = pwdata[0];
            next_col = '0;
            next_row = '0;
          end
          REG_FRAME_WIDTH: begin
            width_reg = pwdata[SIZE_W-1:0];
            next_col = '0;
            next_row = '0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = pwdata[SIZE_W-1:0];
            next_col = '0;
            next_row = '0;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) scale_pixel(pixel_in);
    end
    mismatches <= errors;
    outstanding <= pending_pixels.size();
  end

endmodule

[verif/testbench.sv]
module testbench;
  import isb_pkg::*;

  localparam logic [ADDR_W-3:0] REG_OUT_OF_MAP = 2'd3;
  localparam int LIMIT_TIME = 40_000_000;
  localparam int RANDOM_PIXELS = 96;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   pixel_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               last_of_run;

  int   mismatches;
  int   outstanding;
  int   pixels_sent = 0;
  int   settings_used = 0;
  int   results_seen = 0;
  int   averaged_seen = 0;
  logic shrink_mode = MODE_ZOOM_IN;
  bit   steady = 1'b0;

  image_scale_by_two uut (.*);

  scaled_pixel_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (shrink_mode == MODE_ZOOM_OUT) averaged_seen <= averaged_seen + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size(input int limit);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'($urandom_range(limit + 1, 3 * limit));
      default: return SIZE_W'($urandom_range(1, limit));
    endcase
  endfunction

  // sink side: ready runs with random stalls
  initial begin : sink_stalls
    int hold;
    int gap;
    forever begin
      hold = $urandom_range(1, 16);
      out_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic feed_pixels(input int count);
    repeat (count) send_pixel(rand_pixel());
    in_valid <= 1'b0;
  endtask

  task automatic apb_write(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // all expected transactions out, then room for a zoom-out pixel still in flight
  task automatic drain_and_settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_frame(input logic mode, input logic [SIZE_W-1:0] wval,
                               input logic [SIZE_W-1:0] hval);
    logic [DATA_W-1:0] data;
    drain_and_settle();
    data = $urandom;
    data[0] = mode;
    apb_write(REG_SCALE_MODE, data);
    data = $urandom;
    data[SIZE_W-1:0] = wval;
    apb_write(REG_FRAME_WIDTH, data);
    data = $urandom;
    data[SIZE_W-1:0] = hval;
    apb_write(REG_FRAME_HEIGHT, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shrink_mode = mode;
    settings_used++;
  endtask

  initial begin
    #LIMIT_TIME;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic              mode;
    logic [SIZE_W-1:0] wval;
    logic [SIZE_W-1:0] hval;
    int                weff;
    int                heff;
    int                count;
    int                random_pixels;
    random_pixels = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zoom-in on a 1024 x 1024 frame
    send_pixel(8'h00);
    send_pixel(8'hff);
    in_valid <= 1'b0;

    // small zoom-in frame with wrap into the next frame
    program_frame(MODE_ZOOM_IN, 11'd3, 11'd2);
    send_pixel(8'haa);
    send_pixel(8'h55);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'h7f);
    send_pixel(8'hfe);
    send_pixel(8'h33);
    in_valid <= 1'b0;

    // odd width and height, trailing row and column dropped, full-scale average
    program_frame(MODE_ZOOM_OUT, 11'd3, 11'd3);
    repeat (9) send_pixel(8'hff);
    in_valid <= 1'b0;

    // zero sizes count as one, so no block ever completes
    program_frame(MODE_ZOOM_OUT, 11'd0, 11'd0);
    send_pixel(8'hff);
    send_pixel(8'hff);
    in_valid <= 1'b0;

    // write beyond the register map leaves the frame position alone; average truncates
    program_frame(MODE_ZOOM_OUT, 11'd2, 11'd2);
    send_pixel(8'd0);
    send_pixel(8'd1);
    in_valid <= 1'b0;
    drain_and_settle();
    apb_write(REG_OUT_OF_MAP, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    send_pixel(8'd2);
    send_pixel(8'd3);
    in_valid <= 1'b0;

    // random frames in either mode: zoom-out mostly whole frames, some cut short by a restart
    while (random_pixels < RANDOM_PIXELS) begin
      mode = ($urandom_range(0, 1) == 0) ? MODE_ZOOM_IN : MODE_ZOOM_OUT;
      wval = rand_size(8);
      hval = rand_size(6);
      weff = (wval == '0) ? 1 : int'(wval);
      heff = (hval == '0) ? 1 : int'(hval);
      if (mode == MODE_ZOOM_IN) count = $urandom_range(1, 12);
      else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, weff * heff);
      else count = weff * heff * $urandom_range(1, 2);
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      steady = ($urandom_range(0, 3) == 0);
      program_frame(mode, wval, hval);
      feed_pixels(count);
      random_pixels += count;
    end
    steady = 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d pixels under %0d register settings", pixels_sent, settings_used);
    $display("checked %0d output transactions, %0d of them 2x2 averages",
             results_seen, averaged_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
